FILE: src/de_pkg.sv
// de_pkg: shared constants, emit select codes and the controller/datapath
// command and status structs for the divisor enumerator. No dependencies.
package de_pkg;

  localparam int DATA_W         = 12;  // width of value and divisor ports
  localparam int POS_W          = 6;   // width of the position port
  localparam int VALUE_BITS_DEF = 12;  // default number of value bits used

  // which number goes out with an emit
  typedef enum logic [1:0] {
    SEL_ONE   = 2'd0,
    SEL_CAND  = 2'd1,
    SEL_VALUE = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic      load_value;  // capture the request value, clear count, set candidate to 2
    logic      start_div;   // begin a remainder of held value by candidate
    logic      div_step;    // one restoring step
    logic      inc_cand;    // move to the next candidate
    logic      emit;        // put a result in the output register
    emit_sel_t emit_sel;
    logic      emit_last;
  } de_cmd_t;

  typedef struct packed {
    logic value_zero;
    logic value_one;
    logic cand_in_range;  // candidate <= held value / 2
    logic div_done;
    logic rem_zero;
    logic out_free;       // output register empty or emptied this cycle
  } de_status_t;

endpackage

FILE: src/de_datapath.sv
// de_datapath: value and candidate registers, restoring remainder unit,
// divisor count and output register. Depends on de_pkg.
module de_datapath #(
  parameter int VALUE_BITS = de_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [de_pkg::DATA_W-1:0] value,
  input  de_pkg::de_cmd_t           cmd,
  output de_pkg::de_status_t        status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [de_pkg::DATA_W-1:0] divisor,
  output logic [de_pkg::POS_W-1:0]  position,
  output logic                      last
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]  held_value;
  logic [VALUE_BITS-1:0]  candidate;
  logic [de_pkg::POS_W-1:0] found_count;
  logic [VALUE_BITS-1:0]  rem;
  logic [VALUE_BITS-1:0]  dividend;
  logic [CNT_W-1:0]       step_cnt;

  logic [VALUE_BITS:0]    trial;
  logic [VALUE_BITS:0]    trial_diff;
  logic [VALUE_BITS-1:0]  emit_num;

  // shift in the next dividend bit and subtract when it fits
  assign trial      = {rem, dividend[VALUE_BITS-1]};
  assign trial_diff = trial - {1'b0, candidate};

  always_comb begin
    unique case (cmd.emit_sel)
      de_pkg::SEL_ONE:   emit_num = VALUE_BITS'(1);
      de_pkg::SEL_CAND:  emit_num = candidate;
      de_pkg::SEL_VALUE: emit_num = held_value;
      default:           emit_num = held_value;
    endcase
  end

  assign status.value_zero    = (held_value == '0);
  assign status.value_one     = (held_value == VALUE_BITS'(1));
  assign status.cand_in_range = (candidate <= (held_value >> 1));
  assign status.div_done      = (step_cnt == '0);
  assign status.rem_zero      = (rem == '0);
  assign status.out_free      = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_value  <= '0;
      candidate   <= '0;
      found_count <= '0;
      step_cnt    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load_value) begin
        held_value  <= value[VALUE_BITS-1:0];
        candidate   <= VALUE_BITS'(2);
        found_count <= '0;
      end
      if (cmd.inc_cand) begin
        candidate <= candidate + VALUE_BITS'(1);
      end
      if (cmd.start_div) begin
        step_cnt <= CNT_W'(VALUE_BITS);
      end else if (cmd.div_step) begin
        step_cnt <= step_cnt - CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid   <= 1'b1;
        found_count <= found_count + de_pkg::POS_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      rem      <= '0;
      dividend <= held_value;
    end else if (cmd.div_step) begin
      rem      <= trial_diff[VALUE_BITS] ? trial[VALUE_BITS-1:0]
                                         : trial_diff[VALUE_BITS-1:0];
      dividend <= dividend << 1;
    end
    if (cmd.emit) begin
      divisor  <= de_pkg::DATA_W'(emit_num);
      position <= found_count + de_pkg::POS_W'(1);
      last     <= cmd.emit_last;
    end
  end

endmodule

FILE: src/de_ctrl.sv
// de_ctrl: state machine that sequences the candidates, the remainder steps
// and the emits of the divisor enumerator. Depends on de_pkg.
module de_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  de_pkg::de_status_t status,
  output de_pkg::de_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CHECK    = 7'b0000010,
    S_EMIT_ONE = 7'b0000100,
    S_TEST     = 7'b0001000,
    S_DIV      = 7'b0010000,
    S_JUDGE    = 7'b0100000,
    S_EMIT_VAL = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_sel = de_pkg::SEL_ONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_value = 1'b1;
          state_next     = S_CHECK;
        end
      end
      S_CHECK: begin
        // zero has no divisors
        state_next = status.value_zero ? S_IDLE : S_EMIT_ONE;
      end
      S_EMIT_ONE: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = de_pkg::SEL_ONE;
          cmd.emit_last = status.value_one;
          state_next    = status.value_one ? S_IDLE : S_TEST;
        end
      end
      S_TEST: begin
        if (status.cand_in_range) begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_EMIT_VAL;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_JUDGE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_JUDGE: begin
        if (!status.rem_zero) begin
          cmd.inc_cand = 1'b1;
          state_next   = S_TEST;
        end else if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = de_pkg::SEL_CAND;
          cmd.inc_cand = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_EMIT_VAL: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = de_pkg::SEL_VALUE;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/divisor_enumerator.sv
// divisor_enumerator: top level, lists the divisors of a value in ascending
// order by trial division. Depends on de_pkg, de_ctrl and de_datapath.
//
//   channel  signals                       payload
//   in       in_valid / in_stall           value
//   out      out_valid / out_stall         divisor, position, last
//
// one request at a time; each candidate from 2 to value/2 is tested in turn on
// the single restoring remainder unit, and the next request can be taken in
// the cycle after the last emit
// reset clears the controller, the count and the output valid
// out_stall holds the result register and pauses the enumeration at the
// next divisor found; in_stall is high from acceptance to the last emit
module divisor_enumerator #(
  parameter int VALUE_BITS = de_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [de_pkg::DATA_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [de_pkg::DATA_W-1:0] divisor,
  output logic [de_pkg::POS_W-1:0]  position,
  output logic                      last
);

  de_pkg::de_cmd_t    cmd;
  de_pkg::de_status_t status;

  de_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  de_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .divisor   (divisor),
    .position  (position),
    .last      (last)
  );

endmodule

FILE: verif/divisor_list_checker.sv
`timescale 1ns / 1ps
// divisor_list_checker: watches the request and result channels of the divisor
// enumerator, builds the expected divisor list of each accepted request by trial
// division and compares every result in order. Depends on de_pkg.
module divisor_list_checker #(
  parameter int VALUE_BITS = de_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [de_pkg::DATA_W-1:0] value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [de_pkg::DATA_W-1:0] divisor,
  input  logic [de_pkg::POS_W-1:0]  position,
  input  logic                      last,
  output int                        errors,
  output int                        pending
);

  localparam int MAX_DIVISORS = 48;

  typedef struct packed {
    logic [de_pkg::DATA_W-1:0] divisor;
    logic [de_pkg::POS_W-1:0]  position;
    logic                      last;
  } divisor_entry_t;

  divisor_entry_t expected_divisors[$];

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t divisor list error: %s expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  function automatic void add_divisor(input int d, input int pos, input logic is_last);
    divisor_entry_t e;
    e.divisor  = de_pkg::DATA_W'(d);
    e.position = de_pkg::POS_W'(pos);
    e.last     = is_last;
    expected_divisors.push_back(e);
  endfunction

  function automatic void list_divisors(input logic [de_pkg::DATA_W-1:0] raw);
    int v;
    int count;
    v = int'(raw) & ((1 << VALUE_BITS) - 1);
    // zero lists nothing at all
    if (v == 0) return;
    if (v == 1) begin
      add_divisor(1, 1, 1'b1);
      return;
    end
    add_divisor(1, 1, 1'b0);
    count = 1;
    for (int d = 2; d <= v / 2; d++) begin
      if (v % d == 0 && count < MAX_DIVISORS) begin
        count++;
        add_divisor(d, count, 1'b0);
      end
    end
    // list full: the last one found carries the flag instead of the value
    if (count < MAX_DIVISORS) add_divisor(v, count + 1, 1'b1);
    else expected_divisors[expected_divisors.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    divisor_entry_t want;
    if (rst) begin
      errors = 0;
      expected_divisors.delete();
    end else begin
      if (in_valid && !in_stall) list_divisors(value);
      if (out_valid && !out_stall) begin
        if (expected_divisors.size() == 0) begin
          report_mismatch("divisor with no request pending", 0, divisor);
        end else begin
          want = expected_divisors.pop_front();
          if (divisor !== want.divisor) report_mismatch("divisor", want.divisor, divisor);
          if (position !== want.position) report_mismatch("position", want.position, position);
          if (last !== want.last) report_mismatch("last flag", want.last, last);
        end
      end
    end
    pending = expected_divisors.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: drives requests and result stalls into divisor_enumerator and
// gives the verdict from divisor_list_checker. Depends on de_pkg, the block
// and the checker.
module testbench;

  localparam int CORNER_COUNT  = 16;
  localparam int RANDOM_VALUES = 100;
  localparam int TOTAL_VALUES  = CORNER_COUNT + RANDOM_VALUES;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic [de_pkg::DATA_W-1:0] value;
  logic                      out_stall = 1'b0;
  wire                       in_stall;
  wire                       out_valid;
  wire [de_pkg::DATA_W-1:0]  divisor;
  wire [de_pkg::POS_W-1:0]   position;
  wire                       last;

  int errors;
  int pending;
  int sent = 0;
  int tx_idle = 0;
  int rx_idle = 0;

  // zero, one, small primes and composites, powers of two, the most divisors,
  // all bits set
  int corner_values [CORNER_COUNT] = '{0, 1, 2, 3, 4, 7, 12, 16, 36, 97, 128, 720,
                                       2048, 2520, 4094, 4095};

  divisor_enumerator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .divisor   (divisor),
    .position  (position),
    .last      (last)
  );

  divisor_list_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .divisor   (divisor),
    .position  (position),
    .last      (last),
    .errors    (errors),
    .pending   (pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle);

  task automatic send_value(input int v);
    // idle mix moves through three phases over the whole run
    if (sent < TOTAL_VALUES / 3) begin
      tx_idle = 13;
      rx_idle = 68;
    end else if (sent < 2 * TOTAL_VALUES / 3) begin
      tx_idle = 68;
      rx_idle = 13;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
    if ($urandom_range(99) < tx_idle) begin
      in_valid = 1'b0;
      value    = de_pkg::DATA_W'($urandom);
      @(negedge clk);
      while ($urandom_range(99) < tx_idle) @(negedge clk);
    end
    in_valid = 1'b1;
    value    = de_pkg::DATA_W'(v);
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    value    = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (corner_values[i]) send_value(corner_values[i]);

    // hold requests until every corner list has drained
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);

    // mostly small values keep the run short, one in ten spans the full range
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i % 10 == 0) send_value($urandom_range(4095, 1));
      else send_value($urandom_range(300, 0));
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
src/de_pkg.sv
src/de_datapath.sv
src/de_ctrl.sv
src/divisor_enumerator.sv
verif/divisor_list_checker.sv
verif/testbench.sv
